// File: rtl/core/gcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_pkg
// shared widths, fixed-point constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int ITERATIONS_DEF = 24;

    // raw coordinate widths and the widened difference width
    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    localparam int ANG_IW = 33;

    // datapath widths
    localparam int ZW = 36;     // angle accumulators, q30
    localparam int XW = 34;     // cordic x/y, q30 with headroom
    localparam int QW = 32;     // sines, cosines and products, q30
    localparam int AW = 31;     // haversine term and roots, 0..2^30
    localparam int SQRT_W = 64;
    localparam int SQRT_STEPS = 32;

    localparam int RAD_W = 23;
    localparam int RAD100_W = 30;
    localparam int OUT_W = 32;

    localparam logic [30:0] DEG7_K = 31'd2012227627;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] GAIN_INV_Q30 = 32'd652032874;
    localparam logic [RAD100_W-1:0] RAD100_RESET = 30'd637100000;
    localparam logic [6:0] CM_PER_M = 7'd100;

    // atan(2^-i) in q30, truncated
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            default: begin
                if (i <= 30) begin
                    v = (32'd1 << (30 - i)) - 32'd1;
                end else begin
                    v = 32'd0;
                end
            end
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/gcd_angle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_angle
// 1e-7 degree units to q30 radians, rounded, reduced into [-pi/2, pi/2]
// ----------------------------------------------------------------------------
module gcd_angle (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             en,
    input  wire logic                             in_vld,
    input  wire logic                             half_shift,
    input  wire logic signed [gcd_pkg::ANG_IW-1:0] u_in,
    output logic                                  out_vld,
    output logic signed [gcd_pkg::ZW-1:0]         z_out,
    output logic                                  neg_out
);
    import gcd_pkg::*;

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic sign1_reg, sign2_reg, sign3_reg, sign4_reg;
    logic [ANG_IW-1:0] mag1_reg, mag_next;
    logic [46:0] plo_reg;
    logic [47:0] phi_reg;
    logic [63:0] sum;
    logic [ANG_IW-1:0] r3_reg, r_next;
    logic flip4_reg, flip_next;
    logic signed [ZW-1:0] rr4_reg, rr_next;
    logic signed [ZW-1:0] z5_reg;
    logic neg5_reg;

    assign mag_next = u_in[ANG_IW-1] ? ANG_IW'(-u_in) : ANG_IW'(u_in);

    // round half up on the magnitude
    assign sum = {phi_reg, 16'd0} + 64'(plo_reg)
               + (half_shift ? (64'd1 << 30) : (64'd1 << 29));
    assign r_next = half_shift ? ANG_IW'(sum >> 31) : ANG_IW'(sum >> 30);

    assign flip_next = r3_reg > ANG_IW'(HALF_PI_Q30);
    assign rr_next = flip_next ? $signed(ZW'(r3_reg)) - $signed(ZW'(PI_Q30))
                               : $signed(ZW'(r3_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag_next;
            sign1_reg <= u_in[ANG_IW-1];
            plo_reg   <= 47'(mag1_reg[15:0]) * 47'(DEG7_K);
            phi_reg   <= 48'(mag1_reg[ANG_IW-1:16]) * 48'(DEG7_K);
            sign2_reg <= sign1_reg;
            r3_reg    <= r_next;
            sign3_reg <= sign2_reg;
            rr4_reg   <= rr_next;
            flip4_reg <= flip_next;
            sign4_reg <= sign3_reg;
            z5_reg    <= sign4_reg ? -rr4_reg : rr4_reg;
            neg5_reg  <= flip4_reg;
        end
    end

    assign out_vld = vld5_reg;
    assign z_out   = z5_reg;
    assign neg_out = neg5_reg;

endmodule
`default_nettype wire

// File: rtl/core/gcd_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_sincos
// rotation-mode cordic, one iteration per stage, sign fix in a last stage
// ----------------------------------------------------------------------------
module gcd_sincos #(
    parameter int ITERATIONS = gcd_pkg::ITERATIONS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_vld,
    input  wire logic signed [gcd_pkg::ZW-1:0] z_in,
    input  wire logic                          neg_in,
    output logic                               out_vld,
    output logic signed [gcd_pkg::QW-1:0]      sin_out,
    output logic signed [gcd_pkg::QW-1:0]      cos_out
);
    import gcd_pkg::*;

    logic signed [XW-1:0] x_reg [ITERATIONS];
    logic signed [XW-1:0] y_reg [ITERATIONS];
    logic signed [ZW-1:0] z_reg [ITERATIONS];
    logic                 neg_reg [ITERATIONS];
    logic                 vld_reg [ITERATIONS];
    logic signed [QW-1:0] sin_reg, cos_reg, sin_next, cos_next;
    logic                 vld_out_reg;

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
        logic signed [XW-1:0] x_cur, y_cur, x_next, y_next;
        logic signed [ZW-1:0] z_cur, z_next, step;
        logic                 neg_cur, vld_cur;

        if (i == 0) begin : g_first
            assign x_cur   = $signed(XW'(GAIN_INV_Q30));
            assign y_cur   = '0;
            assign z_cur   = z_in;
            assign neg_cur = neg_in;
            assign vld_cur = in_vld;
        end else begin : g_rest
            assign x_cur   = x_reg[i-1];
            assign y_cur   = y_reg[i-1];
            assign z_cur   = z_reg[i-1];
            assign neg_cur = neg_reg[i-1];
            assign vld_cur = vld_reg[i-1];
        end

        assign step = $signed(ZW'(atan_q30(i)));

        always_comb begin
            if (z_cur >= 0) begin
                x_next = x_cur - (y_cur >>> i);
                y_next = y_cur + (x_cur >>> i);
                z_next = z_cur - step;
            end else begin
                x_next = x_cur + (y_cur >>> i);
                y_next = y_cur - (x_cur >>> i);
                z_next = z_cur + step;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i]   <= x_next;
                y_reg[i]   <= y_next;
                z_reg[i]   <= z_next;
                neg_reg[i] <= neg_cur;
            end
        end
    end

    assign sin_next = neg_reg[ITERATIONS-1] ? QW'(-y_reg[ITERATIONS-1])
                                            : QW'(y_reg[ITERATIONS-1]);
    assign cos_next = neg_reg[ITERATIONS-1] ? QW'(-x_reg[ITERATIONS-1])
                                            : QW'(x_reg[ITERATIONS-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out_reg <= 1'b0;
        end else if (en) begin
            vld_out_reg <= vld_reg[ITERATIONS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign out_vld = vld_out_reg;
    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule
`default_nettype wire

// File: rtl/core/gcd_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_sqrt
// exact bitwise square root of a * 2^30, one result bit per stage
// ----------------------------------------------------------------------------
module gcd_sqrt (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_vld,
    input  wire logic [gcd_pkg::AW-1:0] a_in,
    output logic                        out_vld,
    output logic [gcd_pkg::AW-1:0]      root_out
);
    import gcd_pkg::*;

    logic [SQRT_W-1:0] n_reg [SQRT_STEPS];
    logic [SQRT_W-1:0] r_reg [SQRT_STEPS];
    logic              vld_reg [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (62 - 2 * i);
        logic [SQRT_W-1:0] n_cur, r_cur, n_next, r_next, trial;
        logic              vld_cur;

        if (i == 0) begin : g_first
            assign n_cur   = SQRT_W'(a_in) << 30;
            assign r_cur   = '0;
            assign vld_cur = in_vld;
        end else begin : g_rest
            assign n_cur   = n_reg[i-1];
            assign r_cur   = r_reg[i-1];
            assign vld_cur = vld_reg[i-1];
        end

        assign trial = r_cur + BIT;

        always_comb begin
            if (n_cur >= trial) begin
                n_next = n_cur - trial;
                r_next = (r_cur >> 1) + BIT;
            end else begin
                n_next = n_cur;
                r_next = r_cur >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i] <= n_next;
                r_reg[i] <= r_next;
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STEPS-1];
    assign root_out = r_reg[SQRT_STEPS-1][AW-1:0];

endmodule
`default_nettype wire

// File: rtl/core/gcd_atan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_atan
// vectoring-mode cordic atan2 of two roots, clamped and doubled
// ----------------------------------------------------------------------------
module gcd_atan #(
    parameter int ITERATIONS = gcd_pkg::ITERATIONS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_vld,
    input  wire logic [gcd_pkg::AW-1:0] y_in,
    input  wire logic [gcd_pkg::AW-1:0] x_in,
    output logic                        out_vld,
    output logic [gcd_pkg::QW-1:0]      c_out
);
    import gcd_pkg::*;

    logic signed [XW-1:0] x_reg [ITERATIONS];
    logic signed [XW-1:0] y_reg [ITERATIONS];
    logic signed [ZW-1:0] z_reg [ITERATIONS];
    logic                 vld_reg [ITERATIONS];
    logic [QW-1:0]        c_reg;
    logic [QW-2:0]        zc_next;
    logic                 vld_out_reg;

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
        logic signed [XW-1:0] x_cur, y_cur, x_next, y_next;
        logic signed [ZW-1:0] z_cur, z_next, step;
        logic                 vld_cur;

        if (i == 0) begin : g_first
            assign x_cur   = $signed(XW'(x_in));
            assign y_cur   = $signed(XW'(y_in));
            assign z_cur   = '0;
            assign vld_cur = in_vld;
        end else begin : g_rest
            assign x_cur   = x_reg[i-1];
            assign y_cur   = y_reg[i-1];
            assign z_cur   = z_reg[i-1];
            assign vld_cur = vld_reg[i-1];
        end

        assign step = $signed(ZW'(atan_q30(i)));

        always_comb begin
            if (y_cur < 0) begin
                x_next = x_cur - (y_cur >>> i);
                y_next = y_cur + (x_cur >>> i);
                z_next = z_cur - step;
            end else begin
                x_next = x_cur + (y_cur >>> i);
                y_next = y_cur - (x_cur >>> i);
                z_next = z_cur + step;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    // clamp to [0, pi/2]
    always_comb begin
        if (z_reg[ITERATIONS-1] < 0) begin
            zc_next = '0;
        end else if (z_reg[ITERATIONS-1] > $signed(ZW'(HALF_PI_Q30))) begin
            zc_next = HALF_PI_Q30[QW-2:0];
        end else begin
            zc_next = z_reg[ITERATIONS-1][QW-2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out_reg <= 1'b0;
        end else if (en) begin
            vld_out_reg <= vld_reg[ITERATIONS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= {zc_next, 1'b0};
        end
    end

    assign out_vld = vld_out_reg;
    assign c_out   = c_reg;

endmodule
`default_nettype wire

// File: rtl/core/great_circle_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// great_circle_distance
// fully pipelined fixed-point haversine distance between two lat/lon points
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while s_ready is high: two points in signed
// 1e-7 degree units, returns the great-circle distance in centimetres on a
// sphere whose radius in metres is set through cfg_wr_en/cfg_wr_data (reset
// 6371000, write only while no transaction is in flight). Every stage moves
// forward together, so the sustained rate is one transaction per clock while
// the output buffer has room; the pipeline depth is set by the two chains of
// cordic stages (one iteration each) and the 32-stage bitwise square root. A
// two-entry output buffer lets the pipe keep accepting while one finished
// result waits on m_ready; s_ready drops only when both entries are held.
// ----------------------------------------------------------------------------
module great_circle_distance #(
    parameter int ITERATIONS = gcd_pkg::ITERATIONS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [gcd_pkg::LAT_W-1:0]  s_first_lat,
    input  wire logic signed [gcd_pkg::LON_W-1:0]  s_first_lon,
    input  wire logic signed [gcd_pkg::LAT_W-1:0]  s_second_lat,
    input  wire logic signed [gcd_pkg::LON_W-1:0]  s_second_lon,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [gcd_pkg::OUT_W-1:0]              m_distance_cm,
    input  wire logic                              cfg_wr_en,
    input  wire logic [gcd_pkg::RAD_W-1:0]         cfg_wr_data
);
    import gcd_pkg::*;

    // radius kept pre-scaled to centimetres
    logic [RAD100_W-1:0] rad100_reg;

    // pipeline advance: held only when the output buffer is full
    logic [1:0] cnt_reg;
    logic       en;

    // input stage
    logic                     vld0_reg;
    logic signed [ANG_IW-1:0] lat0_reg, lat1_reg, dlat_reg, dlon_reg;

    // angle conversion lanes
    logic                 ang_vld [4];
    logic signed [ZW-1:0] ang_z [4];
    logic                 ang_neg [4];

    // sine/cosine lanes: 0 lat0, 1 lat1, 2 half dlat, 3 half dlon
    logic                 sc_vld [4];
    logic signed [QW-1:0] sc_sin [4];
    logic signed [QW-1:0] sc_cos [4];

    // haversine term
    logic signed [2*QW-1:0] pr_dp, pr_dl, pr_cc, pr_t;
    logic                   vld_p1_reg, vld_p2_reg, vld_p3_reg, vld_p4_reg;
    logic signed [QW-1:0]   sq_dp1_reg, sq_dl1_reg, cc1_reg;
    logic signed [QW-1:0]   sq_dp2_reg, t2_reg;
    logic signed [QW:0]     a_sum;
    logic [AW-1:0]          a3_next, a3_reg, a4_reg, b4_reg;

    // roots and angle
    logic          sq_vld [2];
    logic [AW-1:0] root_a, root_b;
    logic          at_vld;
    logic [QW-1:0] c_ang;

    // scale and round
    logic                      vld_f1_reg, vld_f2_reg;
    logic [RAD100_W+QW-1:0]    prod_f1_reg;
    logic [RAD100_W+QW-1:0]    rnd_sum;
    logic [OUT_W-1:0]          dist_f2_reg;

    // output buffer
    logic             push, pop;
    logic [OUT_W-1:0] head_reg, tail_reg;

    assign en      = (cnt_reg != 2'd2);
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rad100_reg <= RAD100_RESET;
        end else if (cfg_wr_en) begin
            rad100_reg <= RAD100_W'(cfg_wr_data) * RAD100_W'(CM_PER_M);
        end
    end

    // register the raw points and their differences
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lat0_reg <= ANG_IW'(s_first_lat);
            lat1_reg <= ANG_IW'(s_second_lat);
            dlat_reg <= ANG_IW'(s_second_lat) - ANG_IW'(s_first_lat);
            dlon_reg <= ANG_IW'(s_second_lon) - ANG_IW'(s_first_lon);
        end
    end

    // four angle lanes: the latitudes at full angle, the deltas halved
    gcd_angle u_ang0 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vld0_reg),
        .half_shift(1'b0), .u_in(lat0_reg),
        .out_vld(ang_vld[0]), .z_out(ang_z[0]), .neg_out(ang_neg[0])
    );
    gcd_angle u_ang1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vld0_reg),
        .half_shift(1'b0), .u_in(lat1_reg),
        .out_vld(ang_vld[1]), .z_out(ang_z[1]), .neg_out(ang_neg[1])
    );
    gcd_angle u_ang2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vld0_reg),
        .half_shift(1'b1), .u_in(dlat_reg),
        .out_vld(ang_vld[2]), .z_out(ang_z[2]), .neg_out(ang_neg[2])
    );
    gcd_angle u_ang3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vld0_reg),
        .half_shift(1'b1), .u_in(dlon_reg),
        .out_vld(ang_vld[3]), .z_out(ang_z[3]), .neg_out(ang_neg[3])
    );

    for (genvar k = 0; k < 4; k++) begin : g_sincos
        gcd_sincos #(.ITERATIONS(ITERATIONS)) u_sc (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_vld(ang_vld[k]), .z_in(ang_z[k]), .neg_in(ang_neg[k]),
            .out_vld(sc_vld[k]), .sin_out(sc_sin[k]), .cos_out(sc_cos[k])
        );
    end

    // products of q30 values, floor shift by 30
    assign pr_dp = sc_sin[2] * sc_sin[2];
    assign pr_dl = sc_sin[3] * sc_sin[3];
    assign pr_cc = sc_cos[0] * sc_cos[1];
    assign pr_t  = cc1_reg * sq_dl1_reg;

    // a = sin^2(dlat/2) + cos*cos*sin^2(dlon/2), clamped to [0, 1]
    assign a_sum = (QW+1)'(sq_dp2_reg) + (QW+1)'(t2_reg);

    always_comb begin
        if (a_sum < 0) begin
            a3_next = '0;
        end else if (a_sum > $signed((QW+1)'(ONE_Q30))) begin
            a3_next = ONE_Q30[AW-1:0];
        end else begin
            a3_next = a_sum[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_p1_reg <= 1'b0;
            vld_p2_reg <= 1'b0;
            vld_p3_reg <= 1'b0;
            vld_p4_reg <= 1'b0;
        end else if (en) begin
            vld_p1_reg <= sc_vld[0];
            vld_p2_reg <= vld_p1_reg;
            vld_p3_reg <= vld_p2_reg;
            vld_p4_reg <= vld_p3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_dp1_reg <= pr_dp[2*QW-3:30];
            sq_dl1_reg <= pr_dl[2*QW-3:30];
            cc1_reg    <= pr_cc[2*QW-3:30];
            sq_dp2_reg <= sq_dp1_reg;
            t2_reg     <= pr_t[2*QW-3:30];
            a3_reg     <= a3_next;
            a4_reg     <= a3_reg;
            b4_reg     <= ONE_Q30[AW-1:0] - a3_reg;
        end
    end

    gcd_sqrt u_sqrt_a (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vld_p4_reg),
        .a_in(a4_reg), .out_vld(sq_vld[0]), .root_out(root_a)
    );
    gcd_sqrt u_sqrt_b (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(vld_p4_reg),
        .a_in(b4_reg), .out_vld(sq_vld[1]), .root_out(root_b)
    );

    gcd_atan #(.ITERATIONS(ITERATIONS)) u_atan (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(sq_vld[0]),
        .y_in(root_a), .x_in(root_b), .out_vld(at_vld), .c_out(c_ang)
    );

    // distance = (R*100*c + 2^29) >> 30
    assign rnd_sum = prod_f1_reg + ((RAD100_W+QW)'(1) << 29);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_f1_reg <= 1'b0;
            vld_f2_reg <= 1'b0;
        end else if (en) begin
            vld_f1_reg <= at_vld;
            vld_f2_reg <= vld_f1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_f1_reg <= (RAD100_W+QW)'(rad100_reg) * (RAD100_W+QW)'(c_ang);
            dist_f2_reg <= rnd_sum[30 +: OUT_W];
        end
    end

    // two-entry output buffer, head drives the result port
    assign push = en && vld_f2_reg;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))) begin
            head_reg <= dist_f2_reg;
        end else if (pop && cnt_reg == 2'd2) begin
            head_reg <= tail_reg;
        end
        if (push && cnt_reg == 2'd1 && !pop) begin
            tail_reg <= dist_f2_reg;
        end
    end

    assign m_valid       = (cnt_reg != 2'd0);
    assign m_distance_cm = head_reg;

    // parallel lanes carry identical valid patterns
    a_lanes_ang: assert property (@(posedge aclk) disable iff (!aresetn)
        ang_vld[0] == ang_vld[1] && ang_vld[0] == ang_vld[2]
        && ang_vld[0] == ang_vld[3])
        else $error("angle lanes out of step");

    a_lanes_sc: assert property (@(posedge aclk) disable iff (!aresetn)
        sc_vld[0] == sc_vld[1] && sc_vld[0] == sc_vld[2]
        && sc_vld[0] == sc_vld[3] && sq_vld[0] == sq_vld[1])
        else $error("cordic or root lanes out of step");

    // buffer never overfills
    a_buf_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push)
        else $error("push into full output buffer");

    a_buf_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count overflow");

    // a result not taken by the receiver stays at the buffer head
    a_head_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance_cm))
        else $error("buffered result lost while stalled");

endmodule
`default_nettype wire

// File: test/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker
// watches the point and distance channels and checks each distance
// ----------------------------------------------------------------------------
// Every accepted point pair is turned into an expected distance by a
// fixed-point haversine model. Each accepted distance is compared with the
// oldest expected one.
// ----------------------------------------------------------------------------
module gcd_checker (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    input  wire logic                                 s_ready,
    input  wire logic signed [gcd_pkg::LAT_W-1:0]     s_first_lat,
    input  wire logic signed [gcd_pkg::LON_W-1:0]     s_first_lon,
    input  wire logic signed [gcd_pkg::LAT_W-1:0]     s_second_lat,
    input  wire logic signed [gcd_pkg::LON_W-1:0]     s_second_lon,
    input  wire logic                                 m_valid,
    input  wire logic                                 m_ready,
    input  wire logic [gcd_pkg::OUT_W-1:0]            m_distance_cm,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [gcd_pkg::RAD_W-1:0]            cfg_wr_data,
    output int                                        outstanding,
    output int                                        errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STEPS = gcd_pkg::ITERATIONS_DEF;
    localparam longint unsigned DEG_TO_RAD = 64'd2012227627;
    localparam longint UNIT = 64'sd1073741824;
    localparam longint PI = 64'sd3373259426;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint GAIN = 64'sd652032874;
    localparam longint ARCTAN [11] = '{843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575};

    logic [gcd_pkg::RAD_W-1:0] radius_m;
    logic [31:0]               expected_cm [$];

    function automatic longint arctan_step(int i);
        if (i < 11) return ARCTAN[i];
        if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
        return 0;
    endfunction

    function automatic longint to_radians(longint u, int shift);
        longint unsigned mag, r;
        mag = (u < 0) ? longint'(-u) : longint'(u);
        r = (mag * DEG_TO_RAD + (64'd1 << (shift - 1))) >> shift;
        return (u < 0) ? -longint'(r) : longint'(r);
    endfunction

    task automatic rotate(input longint angle, output longint sn, output longint cs);
        bit     flip;
        longint x, y, z, dx, dy;
        flip = 0;
        x = GAIN;
        y = 0;
        z = angle;
        while (z > HALF_PI) begin z -= PI; flip = !flip; end
        while (z < -HALF_PI) begin z += PI; flip = !flip; end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic longint vector_angle(longint y0, longint x0);
        longint x, y, z, dx, dy;
        x = x0;
        y = y0;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > HALF_PI) z = HALF_PI;
        return z;
    endfunction

    function automatic longint root_q30(longint v);
        longint unsigned n, r, b;
        n = longint'(v) << 30;
        r = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    task automatic haversine_cm(input longint lat0, input longint lon0, input longint lat1,
                                input longint lon1, output logic [31:0] dist_cm);
        longint s0, c0, s1, c1, sp, cp, sl, cl, hav, ang;
        longint unsigned prod;
        rotate(to_radians(lat0, 30), s0, c0);
        rotate(to_radians(lat1, 30), s1, c1);
        rotate(to_radians(lat1 - lat0, 31), sp, cp);
        rotate(to_radians(lon1 - lon0, 31), sl, cl);
        hav = ((sp * sp) >>> 30) + ((((c0 * c1) >>> 30) * ((sl * sl) >>> 30)) >>> 30);
        if (hav < 0) hav = 0;
        if (hav > UNIT) hav = UNIT;
        ang = 2 * vector_angle(root_q30(hav), root_q30(UNIT - hav));
        prod = (longint'(radius_m) * 100 * longint'(ang) + (64'd1 << 29)) >> 30;
        dist_cm = prod[31:0];
    endtask

    assign outstanding = expected_cm.size();

    always @(posedge aclk) begin
        logic [31:0] exp_cm;
        if (!aresetn) begin
            radius_m <= 23'd6371000;
            expected_cm.delete();
            errors <= 0;
        end else begin
            // registers are to be written only while nothing is in flight; the checker does not enforce it
            if (cfg_wr_en) radius_m <= cfg_wr_data;
            if (s_valid && s_ready) begin
                haversine_cm(s_first_lat, s_first_lon, s_second_lat, s_second_lon, exp_cm);
                expected_cm = {expected_cm, exp_cm};
            end
            if (m_valid && m_ready) begin
                if (expected_cm.size() == 0) begin
                    $display("%t unexpected distance: expected none actual %0d",
                             $realtime, m_distance_cm);
                    errors <= errors + 1;
                end else begin
                    exp_cm = expected_cm.pop_front();
                    if (m_distance_cm !== exp_cm) begin
                        $display("%t distance_cm mismatch: expected %0d actual %0d",
                                 $realtime, exp_cm, m_distance_cm);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the great-circle distance pipeline
// ----------------------------------------------------------------------------
// Sends directed and random point pairs under several radius settings and
// idling patterns, including one long output hold-off that fills the pipe;
// the checker beside the block predicts and compares every distance.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LATENCY = 2 * gcd_pkg::ITERATIONS_DEF + 47;
    localparam int  SETTLE = LATENCY + 40;
    localparam longint LIMIT = 400000;
    localparam int  PER_PHASE = 180;
    localparam int  HOLD_LEN = 400;

    logic                              aclk = 0;
    logic                              aresetn = 0;
    logic                              s_valid = 0;
    logic                              s_ready;
    logic signed [gcd_pkg::LAT_W-1:0]  s_first_lat = '0;
    logic signed [gcd_pkg::LON_W-1:0]  s_first_lon = '0;
    logic signed [gcd_pkg::LAT_W-1:0]  s_second_lat = '0;
    logic signed [gcd_pkg::LON_W-1:0]  s_second_lon = '0;
    logic                              m_valid;
    logic                              m_ready = 0;
    logic [gcd_pkg::OUT_W-1:0]         m_distance_cm;
    logic                              cfg_wr_en = 0;
    logic [gcd_pkg::RAD_W-1:0]         cfg_wr_data = '0;
    int                                outstanding;
    int                                errors;

    int     idle_pct = 0;      // chance the sender sits out a cycle
    int     stall_pct = 0;     // chance the receiver drops m_ready
    bit     hold_req = 0;      // ask the receiver for one long stall
    bit     hold_taken = 0;    // the long stall has been started
    int     hold_off = 0;      // remaining cycles of a forced output stall
    longint cycles = 0;

    always #5 aclk = ~aclk;

    great_circle_distance u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_first_lat   (s_first_lat),
        .s_first_lon   (s_first_lon),
        .s_second_lat  (s_second_lat),
        .s_second_lon  (s_second_lon),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_distance_cm (m_distance_cm),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    gcd_checker u_checker (.*);

    // cycle counter guards against a hung pipe
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[great_circle_distance] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when one is pending
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else if (hold_req && !hold_taken) begin
            m_ready <= 0;
            hold_taken <= 1;
            hold_off <= HOLD_LEN - 1;
        end else if (hold_off > 0) begin
            m_ready <= 0;
            hold_off <= hold_off - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one transaction on the point channel; s_valid is held high until s_ready is seen
    task automatic send_pair(longint lat0, longint lon0, longint lat1, longint lon1);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_first_lat = gcd_pkg::LAT_W'(lat0);
        s_first_lon = gcd_pkg::LON_W'(lon0);
        s_second_lat = gcd_pkg::LAT_W'(lat1);
        s_second_lon = gcd_pkg::LON_W'(lon1);
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // radius change only once the pipe has drained
    task automatic set_radius(logic [gcd_pkg::RAD_W-1:0] r);
        @(negedge aclk);
        s_valid = 0;
        wait (outstanding == 0);
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_en = 1;
        cfg_wr_data = r;
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    // mostly legal points; some close pairs to probe tiny distances, some raw bits
    task automatic send_random;
        longint lat0, lon0, lat1, lon1;
        int     kind;
        kind = $urandom_range(9);
        lat0 = longint'($urandom_range(1800000000)) - 900000000;
        lon0 = longint'($urandom_range(32'd3600000000)) - 1800000000;
        if (kind < 4) begin
            lat1 = lat0 + longint'($urandom_range(2000)) - 1000;
            lon1 = lon0 + longint'($urandom_range(2000)) - 1000;
            if (lat1 > 900000000) lat1 = 900000000;
            if (lat1 < -900000000) lat1 = -900000000;
            if (lon1 > 1800000000) lon1 = 1800000000;
            if (lon1 < -1800000000) lon1 = -1800000000;
        end else if (kind < 8) begin
            lat1 = longint'($urandom_range(1800000000)) - 900000000;
            lon1 = longint'($urandom_range(32'd3600000000)) - 1800000000;
        end else begin
            // out-of-range angles, every bit pattern
            lat0 = longint'($signed($urandom() >> 1 << 1) >>> 1);
            lat1 = longint'($signed($urandom()) >>> 1);
            lon0 = longint'($signed($urandom()));
            lon1 = longint'($signed($urandom()));
        end
        send_pair(lat0, lon0, lat1, lon1);
    endtask

    initial begin
        logic [gcd_pkg::RAD_W-1:0] radii [6];
        radii = '{23'd1, 23'd8000000, 23'd0, 23'h7FFFFF, 23'd6371000, 23'd0};
        radii[5] = gcd_pkg::RAD_W'($urandom_range(1, 8000000));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        set_radius(23'd6371000);

        // directed: same point, poles, antipodes, date line, field extremes
        send_pair(0, 0, 0, 0);
        send_pair(900000000, 0, -900000000, 0);
        send_pair(0, 0, 0, 1800000000);
        send_pair(0, -1800000000, 0, 1800000000);
        send_pair(0, 1799999999, 0, -1799999999);
        send_pair(900000000, 1800000000, 900000000, -1800000000);
        send_pair(-900000000, -1800000000, 900000000, 1800000000);
        send_pair(0, 0, 1, 0);
        send_pair(0, 0, 0, 1);
        send_pair(515000000, -1200000, 488500000, 23500000);
        send_pair(123456789, 987654321, 123456789, 987654321);
        send_pair(-1073741824, -2147483648, 1073741823, 2147483647);
        send_pair(1073741823, 2147483647, -1073741824, -2147483648);
        send_pair(-1, -1, 0, 0);
        send_pair(450000000, 900000000, -450000000, -900000000);
        send_pair(899999999, 0, 899999999, 1800000000);
        send_pair(0, 900000000, 0, -900000000);
        send_pair(300000000, 0, -300000000, 1800000000);

        for (int p = 0; p < 6; p++) begin
            set_radius(radii[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            // long output stall while the sender keeps pushing
            if (p == 0) hold_req = 1;
            for (int i = 0; i < PER_PHASE; i++) begin
                send_random();
                if (i == PER_PHASE / 2) begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
            end
        end

        @(negedge aclk);
        s_valid = 0;
        wait (outstanding == 0);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("[great_circle_distance] OK");
        end else begin
            $display("[great_circle_distance] ERROR");
        end
        $finish;
    end
endmodule
